// ===== rtl/core/tpa_pkg.sv =====
// shared widths, result layout and helpers of the timing profile accumulator
package tpa_pkg;

    localparam int SUM_W   = 42;
    localparam int CNT_W   = 27;
    localparam int MEAN_W  = 24;
    localparam int DEV_W   = 25;
    localparam int POW_W   = 5;
    localparam int THR_W   = 16;
    localparam int DVD_W   = SUM_W + 8;
    localparam int STEP_W  = $clog2(DVD_W + 1);
    localparam int ENTRY_W = SUM_W + CNT_W;

    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_FIRST_POWER = 2'd1;
    localparam logic [1:0] CFG_LAST_POWER  = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd2500;
    localparam logic [POW_W-1:0] FIRST_RESET     = 5'd16;
    localparam logic [POW_W-1:0] LAST_RESET      = 5'd17;

    typedef struct packed {
        logic              empty_res;
        logic [DEV_W-1:0]  deviation;
        logic [MEAN_W-1:0] mean_time;
        logic [CNT_W-1:0]  hit_count;
        logic [POW_W-1:0]  reached_power;
        logic              finished;
        logic              profile_point;
        logic              accepted;
    } tpa_result_t;

    // byte value reduced modulo sv by conditional subtraction
    function automatic logic [7:0] mod_symbol(input logic [7:0] b, input logic [8:0] sv);
        logic [16:0] r;
        r = {9'b0, b};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= ({8'b0, sv} << k))
            begin
                r = r - ({8'b0, sv} << k);
            end
        end
        return r[7:0];
    endfunction

endpackage

// ===== rtl/core/tpa_ram.sv =====
// simple dual-port table memory (one write port, one read port) with registered read data
module tpa_ram #(
    parameter int AW = 12,
    parameter int DW = 69
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tpa_divider.sv =====
// bit-serial restoring divider for q8 means, quotient saturated to 24 bits
module tpa_divider
    import tpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [MEAN_W-1:0] quotient
);

    logic [CNT_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[DVD_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : quo_reg[MEAN_W-1:0];

endmodule

// ===== rtl/core/timing_profile_accumulator.sv =====
// top level: sample accumulation, profile point tracking and entry queries
//
// input transfers on s_*: s_tuser is the opcode (0 timed sample, 1 query).
// one result transfer on m_* follows every input transfer, in order.
// a timed sample within threshold updates one table entry per byte
// position by read-modify-write on the table memory, a read state and a
// write state per position. a rejected sample or one after the run
// finished goes straight to its result. a query reads the entry, then runs
// the serial divider for the entry mean and then for the overall mean;
// an empty entry skips both divisions.
// the next input is taken as soon as the engine is free, while the previous
// result still waits in the output register; a stalled receiver holds the
// result and, once the engine has a second result, holds s_tready low.
// after reset the table is cleared one entry a cycle, with s_tready low;
// configuration writes are taken at any time and a write of first_power
// also reloads the current power.
module timing_profile_accumulator
    import tpa_pkg::*;
#(
    parameter int POSITIONS     = 16,
    parameter int SYMBOL_VALUES = 256,
    parameter int MAX_POWER     = 26
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // block_low, block_high, elapsed, query_position, query_value, zero fill
    input  logic [175:0] s_tdata,
    // opcode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted, profile_point, finished, reached_power, hit_count,
    // mean_time, deviation, empty_res, zero fill
    output logic [87:0]  m_tdata
);

    localparam int ENTRIES = POSITIONS * SYMBOL_VALUES;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW      = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam logic [CNT_W-1:0] CEILING = CNT_W'(1) << MAX_POWER;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_QRD  = 4'd4;
    localparam logic [3:0] S_QCHK = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        state_reg;
    logic [AW-1:0]     clr_reg;
    logic [PW-1:0]     pos_reg;
    logic [127:0]      block_reg;
    logic [31:0]       elapsed_reg;
    logic [AW-1:0]     qaddr_reg;
    tpa_result_t       res_reg;
    tpa_result_t       out_reg;
    logic              out_valid_reg;

    logic [THR_W-1:0]  thr_reg;
    logic [POW_W-1:0]  last_reg;
    logic [CNT_W-1:0]  index_reg;
    logic [POW_W-1:0]  power_reg;
    logic [SUM_W-1:0]  total_time_reg;
    logic [CNT_W-1:0]  total_cnt_reg;
    logic              done_reg;

    logic              in_xfer;
    logic [CNT_W-1:0]  index_next;
    logic              in_limit;
    logic              hit_power;
    logic [7:0]        cur_byte;
    logic [AW-1:0]     sample_addr;
    logic              q_range;
    logic [AW-1:0]     q_addr;
    logic              out_load;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [SUM_W-1:0]  rd_sum;
    logic [CNT_W-1:0]  rd_cnt;

    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [MEAN_W-1:0] div_q;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    assign index_next = index_reg + 1'b1;
    assign in_limit   = s_tdata[159:128] <= {16'b0, thr_reg};
    assign hit_power  = (power_reg <= POW_W'(MAX_POWER))
                        && (index_next == (CNT_W'(1) << power_reg));

    assign cur_byte    = block_reg[{4'(pos_reg), 3'b000} +: 8];
    assign sample_addr = AW'(AW'(pos_reg) * AW'(SYMBOL_VALUES))
                         + AW'(mod_symbol(cur_byte, 9'(SYMBOL_VALUES)));
    assign q_range     = ({1'b0, s_tdata[163:160]} < 5'(POSITIONS))
                         && ({1'b0, s_tdata[171:164]} < 9'(SYMBOL_VALUES));
    assign q_addr      = AW'(AW'(s_tdata[163:160]) * AW'(SYMBOL_VALUES))
                         + AW'(s_tdata[171:164]);

    assign rd_sum = mem_rdata[ENTRY_W-1:CNT_W];
    assign rd_cnt = mem_rdata[CNT_W-1:0];

    assign mem_we    = (state_reg == S_CLR) || (state_reg == S_WR);
    assign mem_waddr = (state_reg == S_CLR) ? clr_reg : sample_addr;
    assign mem_wdata = (state_reg == S_CLR) ? '0
                       : {SUM_W'(rd_sum + {10'b0, elapsed_reg}), CNT_W'(rd_cnt + 1'b1)};
    assign mem_raddr = (state_reg == S_QRD) ? qaddr_reg : sample_addr;

    assign div_start    = ((state_reg == S_QCHK) && (rd_cnt != '0))
                          || ((state_reg == S_DIV1) && div_done && (total_cnt_reg != '0));
    assign div_dividend = (state_reg == S_QCHK) ? {rd_sum, 8'b0} : {total_time_reg, 8'b0};
    assign div_divisor  = (state_reg == S_QCHK) ? rd_cnt : total_cnt_reg;

    tpa_ram #(
        .AW (AW),
        .DW (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tpa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration and run statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESHOLD_RESET;
            last_reg       <= LAST_RESET;
            index_reg      <= '0;
            power_reg      <= FIRST_RESET;
            total_time_reg <= '0;
            total_cnt_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (in_xfer && !s_tuser && !done_reg)
            begin
                index_reg <= index_next;
                if (in_limit)
                begin
                    total_time_reg <= total_time_reg + {10'b0, s_tdata[159:128]};
                    total_cnt_reg  <= total_cnt_reg + 1'b1;
                end
                if (hit_power && (power_reg == last_reg))
                begin
                    done_reg <= 1'b1;
                end
                else if (hit_power)
                begin
                    power_reg <= power_reg + 1'b1;
                end
                if (index_next >= CEILING)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD:
                    begin
                        thr_reg <= cfg_wdata[THR_W-1:0];
                    end
                    CFG_FIRST_POWER:
                    begin
                        power_reg <= cfg_wdata[POW_W-1:0];
                    end
                    CFG_LAST_POWER:
                    begin
                        last_reg <= cfg_wdata[POW_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // engine sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    pos_reg <= '0;
                    if (in_xfer)
                    begin
                        if (s_tuser)
                        begin
                            state_reg <= q_range ? S_QRD : S_DONE;
                        end
                        else
                        begin
                            state_reg <= (!done_reg && in_limit) ? S_RD : S_DONE;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    state_reg <= (pos_reg == PW'(POSITIONS - 1)) ? S_DONE : S_RD;
                end
                S_QRD:
                begin
                    state_reg <= S_QCHK;
                end
                S_QCHK:
                begin
                    state_reg <= (rd_cnt == '0) ? S_DONE : S_DIV1;
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        state_reg <= (total_cnt_reg == '0) ? S_DONE : S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload of the current item and its result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            block_reg   <= s_tdata[127:0];
            elapsed_reg <= s_tdata[159:128];
            qaddr_reg   <= q_addr;
            res_reg     <= '0;
            if (s_tuser)
            begin
                res_reg.finished  <= done_reg;
                res_reg.empty_res <= !q_range;
            end
            else if (done_reg)
            begin
                res_reg.finished <= 1'b1;
            end
            else
            begin
                res_reg.accepted      <= in_limit;
                res_reg.profile_point <= hit_power;
                res_reg.reached_power <= hit_power ? power_reg : '0;
                res_reg.finished      <= (hit_power && (power_reg == last_reg))
                                         || (index_next >= CEILING);
            end
        end
        if (state_reg == S_QCHK)
        begin
            if (rd_cnt == '0)
            begin
                res_reg.empty_res <= 1'b1;
            end
            else
            begin
                res_reg.hit_count <= rd_cnt;
            end
        end
        if ((state_reg == S_DIV1) && div_done)
        begin
            res_reg.mean_time <= div_q;
            res_reg.deviation <= {1'b0, div_q};
        end
        if ((state_reg == S_DIV2) && div_done)
        begin
            res_reg.deviation <= {1'b0, res_reg.mean_time} - {1'b0, div_q};
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

// ===== tb/tpa_checker.sv =====
// checker: watches both streams, predicts each result and compares it
module tpa_checker
    import tpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           points_seen,
    output int           queries_seen
);

    localparam int ENTRIES = 16 * 256;

    logic [SUM_W-1:0] sums [ENTRIES];
    logic [CNT_W-1:0] hits [ENTRIES];
    logic [CNT_W-1:0] index_q;
    logic [POW_W-1:0] power_q;
    logic [SUM_W-1:0] all_time;
    logic [CNT_W-1:0] all_count;
    logic             done_q;
    logic [THR_W-1:0] threshold;
    logic [POW_W-1:0] first_pow;
    logic [POW_W-1:0] last_pow;
    tpa_result_t      expected_results[$];

    function automatic logic [MEAN_W-1:0] q8_average(input logic [SUM_W-1:0] s,
                                                      input logic [CNT_W-1:0] c);
        logic [63:0] m;
        if (c == 0)
        begin
            return '0;
        end
        m = ({22'b0, s} << 8) / c;
        return (m > 64'hFFFFFF) ? 24'hFFFFFF : m[MEAN_W-1:0];
    endfunction

    task automatic predict_transfer(input logic op, input logic [175:0] d);
        tpa_result_t r;
        logic [31:0]  el;
        logic [7:0]   b;
        int           idx;
        logic [MEAN_W-1:0] em;
        logic [MEAN_W-1:0] om;
        r = '0;
        el = d[159:128];
        if (!op)
        begin
            if (done_q)
            begin
                r.finished = 1'b1;
            end
            else
            begin
                index_q = index_q + 1'b1;
                if (el <= {16'b0, threshold})
                begin
                    r.accepted = 1'b1;
                    for (int p = 0; p < 16; p++)
                    begin
                        b = d[p*8 +: 8];
                        idx = p * 256 + b;
                        sums[idx] = sums[idx] + el;
                        hits[idx] = hits[idx] + 1'b1;
                    end
                    all_time = all_time + el;
                    all_count = all_count + 1'b1;
                end
                if (power_q <= 26 && {5'b0, index_q} == (32'd1 << power_q))
                begin
                    r.profile_point = 1'b1;
                    r.reached_power = power_q;
                    if (power_q == last_pow)
                    begin
                        done_q = 1'b1;
                    end
                    else
                    begin
                        power_q = power_q + 1'b1;
                    end
                end
                if (index_q >= (27'd1 << 26))
                begin
                    done_q = 1'b1;
                end
                r.finished = done_q;
            end
        end
        else
        begin
            idx = int'(d[163:160]) * 256 + int'(d[171:164]);
            r.finished = done_q;
            if (hits[idx] == 0)
            begin
                r.empty_res = 1'b1;
            end
            else
            begin
                em = q8_average(sums[idx], hits[idx]);
                om = q8_average(all_time, all_count);
                r.hit_count = hits[idx];
                r.mean_time = em;
                r.deviation = {1'b0, em} - {1'b0, om};
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tpa_result_t got;
        tpa_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                sums[i] = '0;
                hits[i] = '0;
            end
            threshold = THRESHOLD_RESET;
            first_pow = FIRST_RESET;
            last_pow = LAST_RESET;
            power_q = FIRST_RESET;
            index_q = '0;
            all_time = '0;
            all_count = '0;
            done_q = 1'b0;
            expected_results.delete();
            fail_count = 0;
            results_seen = 0;
            points_seen = 0;
            queries_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(tpa_result_t)-1:0];
                results_seen++;
                if (got.profile_point)
                begin
                    points_seen++;
                end
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result transfer %h", m_tdata);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[87:$bits(tpa_result_t)] !== '0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch acc %b/%b pt %b/%b fin %b/%b pow %0d/%0d",
                                     want.accepted, got.accepted, want.profile_point,
                                     got.profile_point, want.finished, got.finished,
                                     want.reached_power, got.reached_power);
                            $display("  hits %0d/%0d mean %h/%h dev %h/%h empty %b/%b",
                                     want.hit_count, got.hit_count, want.mean_time,
                                     got.mean_time, want.deviation, got.deviation,
                                     want.empty_res, got.empty_res);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    queries_seen++;
                end
                predict_transfer(s_tuser, s_tdata);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:
                    begin
                        threshold = cfg_wdata;
                    end
                    CFG_FIRST_POWER:
                    begin
                        first_pow = cfg_wdata[POW_W-1:0];
                        power_q = first_pow;
                    end
                    CFG_LAST_POWER:
                    begin
                        last_pow = cfg_wdata[POW_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// testbench top: drives samples, queries and register writes, gives the verdict
module testbench
    import tpa_pkg::*;
();

    localparam int IDLE_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           results_seen;
    int           points_seen;
    int           queries_seen;
    int           idle_cycles;
    int           stall_mode;
    int           sent;
    logic [7:0]   seen_values [16][$];

    timing_profile_accumulator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tpa_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen), .points_seen(points_seen),
        .queries_seen(queries_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern, changes mode now and then
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [63:0] lo, input logic [63:0] hi,
                             input logic [31:0] el, input logic [3:0] pos,
                             input logic [7:0] val);
        s_tuser <= op;
        s_tdata <= {4'b0, val, pos, el, hi, lo};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent++;
        if (!op)
        begin
            for (int p = 0; p < 16; p++)
            begin
                seen_values[p].push_back(p < 8 ? lo[p*8 +: 8] : hi[(p-8)*8 +: 8]);
            end
        end
    endtask

    task automatic idle_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n)
        begin
            @(negedge clk);
        end
    endtask

    task automatic sample(input logic [31:0] el);
        send_item(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, el, 4'd0, 8'd0);
        @(negedge clk);
    endtask

    // query a byte value seen at that position in an earlier sample most of the time, else anything
    task automatic query_random();
        logic [3:0] pos;
        logic [7:0] val;
        pos = 4'($urandom_range(0, 15));
        val = 8'($urandom);
        if (seen_values[pos].size() > 0 && $urandom_range(0, 3) != 0)
        begin
            val = seen_values[pos][$urandom_range(0, seen_values[pos].size() - 1)];
        end
        send_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, pos, val);
        @(negedge clk);
    endtask

    task automatic drain();
        idle_sender(1);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (150)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input int n, input int thr);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0)
                begin
                    idle_sender($urandom_range(1, 40));
                end
            end
            burst--;
            if ($urandom_range(0, 4) == 0)
            begin
                query_random();
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                sample($urandom);
            end
            else
            begin
                sample($urandom_range(0, thr));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b1;
        stall_mode = 0;
        sent = 0;
        repeat (10)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // directed: extremes, empty-entry queries, threshold edge
        query_random();
        send_item(1'b0, '0, '0, 32'd0, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b0, '1, '1, 32'd2500, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b0, '1, '1, 32'd2501, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b0, '1, '1, 32'hFFFFFFFF, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b1, '1, '1, '1, 4'd15, 8'd255);
        @(negedge clk);
        send_item(1'b1, '0, '0, '0, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b1, '0, '0, '0, 4'd7, 8'd1);
        @(negedge clk);
        drain();

        // small power settings with the widest threshold, then samples and queries
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_LAST_POWER, 16'd3);
        write_reg(CFG_FIRST_POWER, 16'd0);
        send_item(1'b0, '1, '1, 32'd65535, 4'd0, 8'd0);
        @(negedge clk);
        send_item(1'b1, '1, '1, '0, 4'd0, 8'd255);
        @(negedge clk);
        for (int i = 0; i < 10; i++)
        begin
            sample($urandom_range(0, 65535));
        end
        query_random();
        drain();

        // random phases across register settings
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_FIRST_POWER, 16'd2);
        write_reg(CFG_LAST_POWER, 16'd9);
        random_phase(350, 3);
        drain();
        write_reg(CFG_THRESHOLD, 16'd4000);
        write_reg(CFG_FIRST_POWER, 16'd26);
        write_reg(CFG_LAST_POWER, 16'd26);
        random_phase(350, 4000);
        drain();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_FIRST_POWER, 16'd5);
        write_reg(CFG_LAST_POWER, 16'd0);
        random_phase(350, 65535);
        drain();
        write_reg(CFG_THRESHOLD, 16'($urandom));
        write_reg(CFG_FIRST_POWER, 16'd10);
        write_reg(CFG_LAST_POWER, 16'd31);
        random_phase(350, 65535);
        drain();

        $display("transfers in %0d, results %0d, queries %0d, profile points %0d",
                 sent, results_seen, queries_seen, points_seen);
        $display("covered threshold edges, early finish, empty entries, means and deviations");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
